>>> rtl/core/hbbc_pkg.sv
// Package: shared types, constants and helpers for the hashed buffer cache.
package hbbc_pkg;

    localparam int NumSlots   = 32;
    localparam int NumBuckets = 13;
    localparam int SlotW      = $clog2(NumSlots);
    localparam int BucketW    = $clog2(NumBuckets);

    typedef enum logic [1:0] {
        FUNC_ACQUIRE = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_PIN     = 2'd2,
        FUNC_UNPIN   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_UNREF    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_RMW_RD,
        S_RMW_WR,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  device_id;
        logic [31:0] block_number;
        logic [4:0]  slot_select;
        logic [31:0] tick_now;
    } req_t;

    typedef struct packed {
        logic [4:0] slot_granted;
        logic       was_hit;
        logic       needs_read;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] block;
        logic [7:0]  refcount;
        logic        valid;
        logic [31:0] last_use;
        logic [31:0] list_order;
        logic [BucketW-1:0] bucket;
    } entry_t;

    // Fold one 4-bit digit into a residue mod NumBuckets, most significant digit first.
    function automatic logic [BucketW-1:0] bucket_step(input logic [BucketW-1:0] acc,
                                                      input logic [3:0] digit);
        logic [BucketW+3:0] x;
        x = {acc, digit};
        for (int k = 3; k >= 0; k--)
        begin
            if (x >= (BucketW+4)'(NumBuckets << k))
                x = x - (BucketW+4)'(NumBuckets << k);
        end
        return BucketW'(x);
    endfunction

endpackage

>>> rtl/core/hbbc_table.sv
// Entry table: one synchronous memory with registered read data.
module hbbc_table (
    input  logic                        clk,
    input  logic                        we,
    input  logic [hbbc_pkg::SlotW-1:0]  waddr,
    input  hbbc_pkg::entry_t            wdata,
    input  logic [hbbc_pkg::SlotW-1:0]  raddr,
    output hbbc_pkg::entry_t            rdata
);
    hbbc_pkg::entry_t mem [hbbc_pkg::NumSlots];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/core/hashed_block_buffer_cache_top.sv
// Top level: request/response channels, scan sequencer and replacement choice.
//
// Usage: one request beat on req (valid/ready), one response beat on rsp.
// Acquire (func 0) first folds the block number into its bucket, one 4-bit
// digit a cycle, most significant digit first, then reads every table entry
// once, one per cycle, keeping running best candidates for hit, same-bucket
// recycle and cross-bucket steal, then does one read-modify-write of the
// chosen entry; when no buffer is free it skips the write and replies with
// status ST_NO_FREE. Release, pin and unpin do a single read-modify-write
// of the selected slot. The table memory has a single read port.
// After reset the block clears and initializes the table, one entry a cycle,
// through all NumSlots entries, with req_ready low. The response is held
// in an output register until taken; a new request is accepted only after
// the previous response beat has gone, so a stalled receiver holds the block.
// Requests are served strictly in order, one at a time.
module hashed_block_buffer_cache_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  hbbc_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output hbbc_pkg::rsp_t   rsp
);
    localparam int SW = hbbc_pkg::SlotW;
    localparam int BW = hbbc_pkg::BucketW;

    hbbc_pkg::state_t state_reg, state_next;
    hbbc_pkg::req_t   req_reg;
    hbbc_pkg::rsp_t   rsp_reg, rsp_next;
    logic             rsp_valid_reg;
    logic [SW:0]      cnt_reg;
    logic [SW-1:0]    scan_idx_reg;
    logic             scan_live_reg;
    logic [31:0]      order_ctr_reg;
    logic [BW-1:0]    req_bkt_reg;
    logic [2:0]       hash_cnt_reg;

    logic             hit_f_reg, rec_f_reg, stl_f_reg;
    logic [SW-1:0]    hit_s_reg, rec_s_reg, stl_s_reg;
    logic [31:0]      hit_o_reg, rec_o_reg, stl_o_reg, stl_t_reg;
    logic [BW-1:0]    stl_b_reg;

    logic [SW-1:0]    sel_reg;
    logic [1:0]       kind_reg;

    logic             we;
    logic [SW-1:0]    waddr, raddr;
    hbbc_pkg::entry_t wdata, rdata;

    hbbc_table u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    localparam logic [1:0] K_HIT = 2'd0;
    localparam logic [1:0] K_REC = 2'd1;
    localparam logic [1:0] K_STL = 2'd2;

    assign req_ready = (state_reg == hbbc_pkg::S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    logic e_hit, e_rec, e_stl, stl_better;
    always_comb
    begin
        e_hit = (rdata.device == req_reg.device_id) && (rdata.block == req_reg.block_number);
        e_rec = (rdata.refcount == 8'd0) && (rdata.bucket == req_bkt_reg);
        e_stl = (rdata.refcount == 8'd0) && (rdata.bucket != req_bkt_reg);
        if (!stl_f_reg)
            stl_better = 1'b1;
        else if (rdata.last_use != stl_t_reg)
            stl_better = rdata.last_use < stl_t_reg;
        else if (rdata.bucket != stl_b_reg)
            stl_better = rdata.bucket < stl_b_reg;
        else
            stl_better = rdata.list_order < stl_o_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbbc_pkg::S_INIT:
                if (cnt_reg == (SW+1)'(hbbc_pkg::NumSlots - 1))
                    state_next = hbbc_pkg::S_IDLE;
            hbbc_pkg::S_IDLE:
                if (req_valid && req_ready)
                begin
                    if (req.func == hbbc_pkg::FUNC_ACQUIRE)
                        state_next = hbbc_pkg::S_HASH;
                    else
                        state_next = hbbc_pkg::S_RMW_RD;
                end
            hbbc_pkg::S_HASH:
                if (hash_cnt_reg == 3'd0)
                    state_next = hbbc_pkg::S_SCAN;
            hbbc_pkg::S_SCAN:
                if (cnt_reg == (SW+1)'(hbbc_pkg::NumSlots - 1))
                    state_next = hbbc_pkg::S_DRAIN;
            hbbc_pkg::S_DRAIN:  state_next = hbbc_pkg::S_DECIDE;
            hbbc_pkg::S_DECIDE:
                if (!hit_f_reg && !rec_f_reg && !stl_f_reg)
                    state_next = hbbc_pkg::S_REPLY;
                else
                    state_next = hbbc_pkg::S_RMW_RD;
            hbbc_pkg::S_RMW_RD: state_next = hbbc_pkg::S_RMW_WR;
            hbbc_pkg::S_RMW_WR: state_next = hbbc_pkg::S_REPLY;
            hbbc_pkg::S_REPLY:  state_next = hbbc_pkg::S_IDLE;
            default:            state_next = hbbc_pkg::S_INIT;
        endcase
    end

    // Memory access and response: table init, scan reads and the modify step
    always_comb
    begin
        we       = 1'b0;
        waddr    = sel_reg;
        wdata    = rdata;
        raddr    = sel_reg;
        rsp_next = rsp_reg;
        case (state_reg)
            hbbc_pkg::S_INIT:
            begin
                we    = 1'b1;
                waddr = cnt_reg[SW-1:0];
                wdata = '0;
                wdata.list_order = 32'(cnt_reg);
            end
            hbbc_pkg::S_SCAN:  raddr = cnt_reg[SW-1:0];
            hbbc_pkg::S_DECIDE:
                rsp_next = '{slot_granted: '0, was_hit: 1'b0, needs_read: 1'b0,
                             status: hbbc_pkg::ST_NO_FREE};
            hbbc_pkg::S_RMW_WR:
            begin
                rsp_next = '{slot_granted: 5'(sel_reg), was_hit: 1'b0, needs_read: 1'b0,
                             status: hbbc_pkg::ST_OK};
                if (req_reg.func == hbbc_pkg::FUNC_ACQUIRE)
                begin
                    if (kind_reg == K_HIT)
                    begin
                        rsp_next.was_hit = 1'b1;
                        if (rdata.refcount == 8'hFF)
                            rsp_next.status = hbbc_pkg::ST_OVERFLOW;
                        else
                        begin
                            rsp_next.needs_read = !rdata.valid;
                            we = 1'b1;
                            wdata.refcount = rdata.refcount + 8'd1;
                            wdata.last_use = req_reg.tick_now;
                            wdata.valid    = 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_next.needs_read = 1'b1;
                        we = 1'b1;
                        wdata.device   = req_reg.device_id;
                        wdata.block    = req_reg.block_number;
                        wdata.bucket   = req_bkt_reg;
                        wdata.refcount = 8'd1;
                        wdata.last_use = req_reg.tick_now;
                        wdata.valid    = 1'b1;
                        if (kind_reg == K_STL)
                            wdata.list_order = order_ctr_reg;
                    end
                end
                else
                begin
                    rsp_next.slot_granted = req_reg.slot_select;
                    if (req_reg.func == hbbc_pkg::FUNC_PIN)
                    begin
                        if (rdata.refcount == 8'hFF)
                            rsp_next.status = hbbc_pkg::ST_OVERFLOW;
                        else
                        begin
                            we = 1'b1;
                            wdata.refcount = rdata.refcount + 8'd1;
                        end
                    end
                    else if (rdata.refcount == 8'd0)
                        rsp_next.status = hbbc_pkg::ST_UNREF;
                    else
                    begin
                        we = 1'b1;
                        wdata.refcount = rdata.refcount - 8'd1;
                        if (req_reg.func == hbbc_pkg::FUNC_RELEASE)
                        begin
                            wdata.last_use = req_reg.tick_now;
                            if (rdata.refcount == 8'd1)
                                wdata.list_order = order_ctr_reg;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    logic bump_order;
    assign bump_order = (state_reg == hbbc_pkg::S_RMW_WR) && we &&
                        (((req_reg.func == hbbc_pkg::FUNC_ACQUIRE) && (kind_reg == K_STL)) ||
                         ((req_reg.func == hbbc_pkg::FUNC_RELEASE) &&
                          (rdata.refcount == 8'd1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbbc_pkg::S_INIT;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            order_ctr_reg <= 32'(hbbc_pkg::NumSlots);
            scan_live_reg <= 1'b0;
            hit_f_reg     <= 1'b0;
            rec_f_reg     <= 1'b0;
            stl_f_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_live_reg <= (state_reg == hbbc_pkg::S_SCAN);
            if (bump_order)
                order_ctr_reg <= order_ctr_reg + 32'd1;
            if (state_reg == hbbc_pkg::S_INIT || state_reg == hbbc_pkg::S_SCAN)
                cnt_reg <= (cnt_reg == (SW+1)'(hbbc_pkg::NumSlots - 1)) ? '0
                           : cnt_reg + (SW+1)'(1);
            if (state_reg == hbbc_pkg::S_IDLE)
            begin
                hit_f_reg <= 1'b0;
                rec_f_reg <= 1'b0;
                stl_f_reg <= 1'b0;
            end
            else if (scan_live_reg)
            begin
                if (e_hit && (!hit_f_reg || rdata.list_order > hit_o_reg))
                    hit_f_reg <= 1'b1;
                if (e_rec && (!rec_f_reg || rdata.list_order < rec_o_reg))
                    rec_f_reg <= 1'b1;
                if (e_stl && stl_better)
                    stl_f_reg <= 1'b1;
            end
            if (state_reg == hbbc_pkg::S_REPLY)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (state_reg == hbbc_pkg::S_IDLE && req_valid && req_ready)
        begin
            req_reg      <= req;
            req_bkt_reg  <= '0;
            hash_cnt_reg <= 3'd7;
            sel_reg      <= req.slot_select[SW-1:0];
        end
        if (state_reg == hbbc_pkg::S_HASH)
        begin
            req_bkt_reg  <= hbbc_pkg::bucket_step(req_bkt_reg,
                                req_reg.block_number[{hash_cnt_reg, 2'b00} +: 4]);
            hash_cnt_reg <= hash_cnt_reg - 3'd1;
        end
        scan_idx_reg <= cnt_reg[SW-1:0];
        if (scan_live_reg)
        begin
            if (e_hit && (!hit_f_reg || rdata.list_order > hit_o_reg))
            begin
                hit_s_reg <= scan_idx_reg;
                hit_o_reg <= rdata.list_order;
            end
            if (e_rec && (!rec_f_reg || rdata.list_order < rec_o_reg))
            begin
                rec_s_reg <= scan_idx_reg;
                rec_o_reg <= rdata.list_order;
            end
            if (e_stl && stl_better)
            begin
                stl_s_reg <= scan_idx_reg;
                stl_o_reg <= rdata.list_order;
                stl_t_reg <= rdata.last_use;
                stl_b_reg <= rdata.bucket;
            end
        end
        if (state_reg == hbbc_pkg::S_DECIDE)
        begin
            if (hit_f_reg)
            begin
                sel_reg  <= hit_s_reg;
                kind_reg <= K_HIT;
            end
            else if (rec_f_reg)
            begin
                sel_reg  <= rec_s_reg;
                kind_reg <= K_REC;
            end
            else
            begin
                sel_reg  <= stl_s_reg;
                kind_reg <= K_STL;
            end
        end
    end
endmodule

>>> verif/hashed_block_buffer_cache_top_test.sv
// Testbench: random and directed traffic through the hashed buffer cache, checked against a predictor.
`timescale 1ns / 100ps

module hashed_block_buffer_cache_top_test;

    localparam int WatchdogLimit = 20000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    hbbc_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    hbbc_pkg::rsp_t rsp;

    hashed_block_buffer_cache_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    logic [7:0]  buf_device [hbbc_pkg::NumSlots];
    logic [31:0] buf_block [hbbc_pkg::NumSlots];
    logic [7:0]  buf_refs [hbbc_pkg::NumSlots];
    logic        buf_valid [hbbc_pkg::NumSlots];
    logic [31:0] buf_tick [hbbc_pkg::NumSlots];
    logic [31:0] buf_order [hbbc_pkg::NumSlots];
    logic [31:0] next_order;

    hbbc_pkg::req_t pending_reqs [$];
    hbbc_pkg::rsp_t expected_rsps [$];
    int   fail_count;
    int   quiet_cycles;
    bit   stim_done;
    bit   calm;

    function automatic int hash_bucket(logic [31:0] blk);
        return int'(blk % hbbc_pkg::NumBuckets);
    endfunction

    function automatic hbbc_pkg::rsp_t cache_lookup(hbbc_pkg::req_t r);
        hbbc_pkg::rsp_t o;
        int pick;
        int bk;
        logic [4:0] s5;
        o = '0;
        pick = -1;
        s5 = r.slot_select;
        if (r.func == hbbc_pkg::FUNC_ACQUIRE)
        begin
            bk = hash_bucket(r.block_number);
            for (int s = 0; s < hbbc_pkg::NumSlots; s++)
                if (buf_device[s] == r.device_id && buf_block[s] == r.block_number)
                    if (pick < 0 || buf_order[s] > buf_order[pick])
                        pick = s;
            if (pick >= 0)
            begin
                o.slot_granted = 5'(pick);
                o.was_hit = 1'b1;
                if (buf_refs[pick] == 8'd255)
                begin
                    o.status = hbbc_pkg::ST_OVERFLOW;
                    return o;
                end
                buf_refs[pick]++;
                buf_tick[pick] = r.tick_now;
                o.needs_read = !buf_valid[pick];
                buf_valid[pick] = 1'b1;
                o.status = hbbc_pkg::ST_OK;
                return o;
            end
            for (int s = 0; s < hbbc_pkg::NumSlots; s++)
                if (buf_refs[s] == 0 && hash_bucket(buf_block[s]) == bk)
                    if (pick < 0 || buf_order[s] < buf_order[pick])
                        pick = s;
            if (pick < 0)
            begin
                for (int s = 0; s < hbbc_pkg::NumSlots; s++)
                begin
                    int b;
                    bit better;
                    b = hash_bucket(buf_block[s]);
                    if (buf_refs[s] != 0 || b == bk)
                        continue;
                    if (pick < 0)
                        better = 1;
                    else if (buf_tick[s] != buf_tick[pick])
                        better = buf_tick[s] < buf_tick[pick];
                    else if (b != hash_bucket(buf_block[pick]))
                        better = b < hash_bucket(buf_block[pick]);
                    else
                        better = buf_order[s] < buf_order[pick];
                    if (better)
                        pick = s;
                end
                if (pick < 0)
                begin
                    o.status = hbbc_pkg::ST_NO_FREE;
                    return o;
                end
                buf_order[pick] = next_order;
                next_order++;
            end
            buf_device[pick] = r.device_id;
            buf_block[pick] = r.block_number;
            buf_refs[pick] = 8'd1;
            buf_tick[pick] = r.tick_now;
            buf_valid[pick] = 1'b1;
            o.slot_granted = 5'(pick);
            o.needs_read = 1'b1;
            o.status = hbbc_pkg::ST_OK;
            return o;
        end
        o.slot_granted = s5;
        if (r.func == hbbc_pkg::FUNC_PIN)
        begin
            if (buf_refs[s5] == 8'd255)
            begin
                o.status = hbbc_pkg::ST_OVERFLOW;
                return o;
            end
            buf_refs[s5]++;
            o.status = hbbc_pkg::ST_OK;
            return o;
        end
        if (buf_refs[s5] == 0)
        begin
            o.status = hbbc_pkg::ST_UNREF;
            return o;
        end
        buf_refs[s5]--;
        if (r.func == hbbc_pkg::FUNC_RELEASE)
        begin
            if (buf_refs[s5] == 0)
            begin
                buf_order[s5] = next_order;
                next_order++;
            end
            buf_tick[s5] = r.tick_now;
        end
        o.status = hbbc_pkg::ST_OK;
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic push_req(hbbc_pkg::func_t f, logic [7:0] dev, logic [31:0] blk,
                            logic [4:0] s, logic [31:0] tk);
        hbbc_pkg::req_t r;
        r.func = f;
        r.device_id = dev;
        r.block_number = blk;
        r.slot_select = s;
        r.tick_now = tk;
        pending_reqs.push_back(r);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 11))
            begin
                req_valid <= 1'b1;
                req <= pending_reqs.pop_front();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= calm || $urandom_range(99) >= 11;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_rsps.push_back(cache_lookup(req));
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("unexpected response", 1, 0);
                end
                else
                begin
                    hbbc_pkg::rsp_t w;
                    w = expected_rsps.pop_front();
                    if (rsp.slot_granted != w.slot_granted)
                        report_mismatch("slot_granted", rsp.slot_granted, w.slot_granted);
                    if (rsp.was_hit != w.was_hit)
                        report_mismatch("was_hit", rsp.was_hit, w.was_hit);
                    if (rsp.needs_read != w.needs_read)
                        report_mismatch("needs_read", rsp.needs_read, w.needs_read);
                    if (rsp.status != w.status)
                        report_mismatch("status", rsp.status, w.status);
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] tk;
        logic [31:0] blk;
        int n;
        fail_count = 0;
        quiet_cycles = 0;
        stim_done = 0;
        calm = 0;
        next_order = 32'(hbbc_pkg::NumSlots);
        for (int s = 0; s < hbbc_pkg::NumSlots; s++)
        begin
            buf_device[s] = '0;
            buf_block[s] = '0;
            buf_refs[s] = '0;
            buf_valid[s] = 1'b0;
            buf_tick[s] = '0;
            buf_order[s] = 32'(s);
        end
        tk = 100;
        for (int i = 0; i < 255; i++)
            push_req(hbbc_pkg::FUNC_PIN, 8'd0, 32'd0, 5'd31, tk);
        push_req(hbbc_pkg::FUNC_ACQUIRE, 8'd0, 32'd0, 5'd0, tk);
        push_req(hbbc_pkg::FUNC_PIN, 8'd0, 32'd0, 5'd31, tk);
        push_req(hbbc_pkg::FUNC_UNPIN, 8'd0, 32'd0, 5'd31, tk);
        push_req(hbbc_pkg::FUNC_ACQUIRE, 8'd0, 32'd0, 5'd0, tk);
        push_req(hbbc_pkg::FUNC_ACQUIRE, 8'd0, 32'd0, 5'd31, tk + 1);
        push_req(hbbc_pkg::FUNC_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
        push_req(hbbc_pkg::FUNC_RELEASE, 8'd0, 32'd0, 5'd31, tk + 2);
        push_req(hbbc_pkg::FUNC_RELEASE, 8'd0, 32'd0, 5'd31, tk + 3);
        push_req(hbbc_pkg::FUNC_RELEASE, 8'd0, 32'd0, 5'd31, tk + 4);
        push_req(hbbc_pkg::FUNC_UNPIN, 8'd0, 32'd0, 5'd5, tk);
        push_req(hbbc_pkg::FUNC_RELEASE, 8'd0, 32'd0, 5'd0, tk);
        push_req(hbbc_pkg::FUNC_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd7, 32'd0);
        push_req(hbbc_pkg::FUNC_UNPIN, 8'd0, 32'd0, 5'd7, tk);
        for (int i = 0; i < 34; i++)
            push_req(hbbc_pkg::FUNC_ACQUIRE, 8'd1, 32'd1000 + 32'(i), 5'd0,
                     tk + 32'd10 + 32'(i));
        for (int s = 0; s < hbbc_pkg::NumSlots; s++)
            for (int k = 0; k < 2; k++)
                push_req(hbbc_pkg::FUNC_RELEASE, 8'd0, 32'd0, 5'(s), 32'($urandom));
        for (int i = 0; i < 160; i++)
        begin
            n = $urandom_range(99);
            blk = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(40));
            if (n < 45)
                push_req(hbbc_pkg::FUNC_ACQUIRE,
                         ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2)),
                         blk, 5'($urandom),
                         $urandom_range(1) ? 32'($urandom) : tk + 32'(i));
            else if (n < 80)
                push_req(hbbc_pkg::FUNC_RELEASE, 8'($urandom), 32'($urandom), 5'($urandom),
                         $urandom_range(1) ? 32'($urandom) : tk + 32'(i));
            else if (n < 90)
                push_req(hbbc_pkg::FUNC_PIN, 8'($urandom), 32'($urandom), 5'($urandom),
                         32'($urandom));
            else
                push_req(hbbc_pkg::FUNC_UNPIN, 8'($urandom), 32'($urandom), 5'($urandom),
                         32'($urandom));
            if (i == 100)
                push_req(hbbc_pkg::FUNC_ACQUIRE, 8'd0, 32'd0, 5'd0, tk);
        end
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() < 300);
        calm = 1;
        wait (pending_reqs.size() < 150);
        calm = 0;
        wait (pending_reqs.size() == 0 && !req_valid);
        wait (expected_rsps.size() == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
